[src/hsc_pkg.sv]
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types and constants for the HSV histogram skin classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

  localparam int LIKELIHOOD_WIDTH_DEF = 16;
  localparam int BIN_COUNT            = 256;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_LOAD  = 1'b1;

  // Divider widths: hue numerator is 255 * |I*d + F| (at most 255 * 1275).
  localparam int HREM_W = 19;
  localparam int HDEN_W = 11;
  localparam int HQ_W   = 8;
  localparam int SREM_W = 16;
  localparam int SDEN_W = 12;
  localparam int SQ_W   = 4;
  localparam int DIV_STAGES = 4;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  bin_index;
    logic [15:0] skin_value;
    logic [15:0] nonskin_value;
  } req_t;

  typedef struct packed {
    logic [7:0] out_pixel;
    logic       is_skin;
  } res_t;

  typedef struct packed {
    logic              is_load;
    logic [7:0]        bin_index;
    logic [15:0]       skin_value;
    logic [15:0]       nonskin_value;
    logic [7:0]        v;
    logic [HREM_W-1:0] hrem;
    logic [HDEN_W-1:0] hden;
    logic [HQ_W-1:0]   hq;
    logic              hneg;
    logic [SREM_W-1:0] srem;
    logic [SDEN_W-1:0] sden;
    logic [SQ_W-1:0]   sq;
  } div_t;

endpackage

`default_nettype wire

[src/hsv_histogram_skin_classifier_unit.sv]
// ----------------------------------------------------------------------------
// hsv_histogram_skin_classifier_unit
// Per-pixel skin classifier: RGB to HSV bin, likelihood table lookup, compare.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                       Payload
//  req      req_valid / req_stall / req   req_t: pixel or table load
//  res      res_valid / res_stall / res   res_t: one per pixel transaction
//
// One transaction enters per cycle while req_stall is low. A pixel passes
// the front stage, four divider stages, the table read and the
// compare stage, each registered. Loads write the tables in order with pixels.
// Reset clears only the valid bits; tables hold unknown data until loaded.
// A stall on res holds each stage only where a full stage is blocked.
`default_nettype none

module hsv_histogram_skin_classifier_unit import hsc_pkg::*; #(
  parameter int LIKELIHOOD_WIDTH = LIKELIHOOD_WIDTH_DEF
) (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic req_valid,
  output logic       req_stall,
  input  wire  req_t req,
  output logic       res_valid,
  input  wire  logic res_stall,
  output res_t       res
);

  // Front stage: max, min, difference and divider operands.
  logic [7:0]        vmax;
  logic [7:0]        xmin;
  logic [7:0]        d;
  logic signed [11:0] num;
  logic [10:0]       mag;
  div_t              front_next;
  div_t              front;
  logic              front_valid;
  logic              front_stall;

  logic [DIV_STAGES:0] dv_valid;
  logic [DIV_STAGES:0] dv_stall;
  div_t                dv_data [DIV_STAGES+1];

  always_comb begin
    vmax = req.red;
    if (req.green > vmax) vmax = req.green;
    if (req.blue > vmax) vmax = req.blue;
    xmin = req.red;
    if (req.green < xmin) xmin = req.green;
    if (req.blue < xmin) xmin = req.blue;
    d = vmax - xmin;
    if (req.red == vmax) begin
      num = 12'(signed'({1'b0, req.green})) - 12'(signed'({1'b0, req.blue}));
    end else if (req.green == vmax) begin
      num = 12'(signed'({1'b0, d, 1'b0}))
          + 12'(signed'({1'b0, req.blue})) - 12'(signed'({1'b0, req.red}));
    end else begin
      num = 12'(signed'({1'b0, d, 2'b00}))
          + 12'(signed'({1'b0, req.red})) - 12'(signed'({1'b0, req.green}));
    end
    mag = num[11] ? 11'(-num) : num[10:0];

    front_next.is_load       = (req.req_type == REQ_LOAD);
    front_next.bin_index     = req.bin_index;
    front_next.skin_value    = req.skin_value;
    front_next.nonskin_value = req.nonskin_value;
    front_next.v             = vmax;
    front_next.hq            = '0;
    front_next.sq            = '0;
    if (d == 8'd0) begin
      // Gray pixel: zero numerators over unit divisors give H = S = 0.
      front_next.hrem = '0;
      front_next.hden = HDEN_W'(1);
      front_next.hneg = 1'b0;
      front_next.srem = '0;
      front_next.sden = SDEN_W'(1);
    end else begin
      front_next.hrem = (HREM_W'(mag) << 8) - HREM_W'(mag);
      front_next.hden = (HDEN_W'(d) << 2) + (HDEN_W'(d) << 1);
      front_next.hneg = num[11];
      front_next.srem = (SREM_W'(d) << 8) - SREM_W'(d);
      front_next.sden = SDEN_W'(vmax) << 4;
    end
  end

  assign front_stall = front_valid && dv_stall[0];
  assign req_stall   = front_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (!front_stall) begin
      front_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!front_stall) begin
      front <= front_next;
    end
  end

  assign dv_valid[0] = front_valid;
  assign dv_data[0]  = front;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    hsc_div_stage #(.STEP(i)) u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv_valid[i]),
      .in_stall  (dv_stall[i]),
      .in_data   (dv_data[i]),
      .out_valid (dv_valid[i+1]),
      .out_stall (dv_stall[i+1]),
      .out_data  (dv_data[i+1])
    );
  end

  // Table stage: loads write here, pixels read here, in arrival order.
  logic [LIKELIHOOD_WIDTH-1:0] skin_table    [BIN_COUNT];
  logic [LIKELIHOOD_WIDTH-1:0] nonskin_table [BIN_COUNT];
  logic [LIKELIHOOD_WIDTH-1:0] skin_rd;
  logic [LIKELIHOOD_WIDTH-1:0] nonskin_rd;
  logic [31:0]                 skin_ext;
  logic [31:0]                 nonskin_ext;
  logic [7:0]                  hue;
  logic [7:0]                  rd_bin;
  logic [7:0]                  tab_v;
  logic                        tab_valid;
  logic                        tab_stall;
  div_t                        last;
  logic                        out_stall;
  res_t                        res_next;

  assign last        = dv_data[DIV_STAGES];
  assign skin_ext    = 32'(last.skin_value);
  assign nonskin_ext = 32'(last.nonskin_value);

  always_comb begin
    // A negative hue quotient wraps by adding 255.
    if (last.hneg && last.hq != '0) begin
      hue = 8'd255 - last.hq;
    end else begin
      hue = last.hq;
    end
    rd_bin = {hue[7:4], last.sq};
  end

  assign out_stall = res_valid && res_stall;
  assign tab_stall = tab_valid && out_stall;
  assign dv_stall[DIV_STAGES] = tab_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_valid <= 1'b0;
    end else if (!tab_stall) begin
      tab_valid <= dv_valid[DIV_STAGES] && !last.is_load;
    end
  end

  always_ff @(posedge clk) begin
    if (!tab_stall && dv_valid[DIV_STAGES] && last.is_load) begin
      skin_table[last.bin_index]    <= skin_ext[LIKELIHOOD_WIDTH-1:0];
      nonskin_table[last.bin_index] <= nonskin_ext[LIKELIHOOD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!tab_stall) begin
      skin_rd    <= skin_table[rd_bin];
      nonskin_rd <= nonskin_table[rd_bin];
      tab_v      <= last.v;
    end
  end

  // Output stage.
  always_comb begin
    res_next.is_skin   = skin_rd > nonskin_rd;
    res_next.out_pixel = res_next.is_skin ? tab_v : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!out_stall) begin
      res_valid <= tab_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_stall) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

[src/hsc_div_stage.sv]
// ----------------------------------------------------------------------------
// hsc_div_stage
// One registered stage of the restoring dividers: two hue quotient bits and
// one saturation quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_div_stage import hsc_pkg::*; #(
  parameter int STEP = 0
) (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic in_valid,
  output logic       in_stall,
  input  wire  div_t in_data,
  output logic       out_valid,
  input  wire  logic out_stall,
  output div_t       out_data
);

  localparam int KH0 = HQ_W - 1 - 2 * STEP;
  localparam int KH1 = HQ_W - 2 - 2 * STEP;
  localparam int KS  = SQ_W - 1 - STEP;

  div_t              data_next;
  logic [HREM_W-1:0] sh0;
  logic [HREM_W-1:0] sh1;
  logic [SREM_W-1:0] ss;

  always_comb begin
    data_next = in_data;
    sh0 = HREM_W'(data_next.hden) << KH0;
    if (data_next.hrem >= sh0) begin
      data_next.hrem = data_next.hrem - sh0;
      data_next.hq[KH0] = 1'b1;
    end
    sh1 = HREM_W'(data_next.hden) << KH1;
    if (data_next.hrem >= sh1) begin
      data_next.hrem = data_next.hrem - sh1;
      data_next.hq[KH1] = 1'b1;
    end
    ss = SREM_W'(data_next.sden) << KS;
    if (data_next.srem >= ss) begin
      data_next.srem = data_next.srem - ss;
      data_next.sq[KS] = 1'b1;
    end
  end

  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

[tb/hsv_histogram_skin_classifier_unit_test.sv]
// ----------------------------------------------------------------------------
// hsv_histogram_skin_classifier_unit_test
// Loads the likelihood tables, then drives directed and random pixels and
// loads with random idling on both channels; results are checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import hsc_pkg::*;

class skin_scoreboard;
  logic [15:0] skin_lk[BIN_COUNT];
  logic [15:0] nonskin_lk[BIN_COUNT];
  res_t pending[$];
  int errors;

  function void note_request(req_t r);
    int v, x, d, i, f, h, s;
    logic [7:0] idx;
    res_t e;
    if (r.req_type == REQ_LOAD) begin
      skin_lk[r.bin_index] = r.skin_value;
      nonskin_lk[r.bin_index] = r.nonskin_value;
      return;
    end
    v = r.red; if (r.green > v) v = r.green; if (r.blue > v) v = r.blue;
    x = r.red; if (r.green < x) x = r.green; if (r.blue < x) x = r.blue;
    h = 0; s = 0;
    if (v != x) begin
      d = v - x;
      s = (255 * d) / v;
      if (r.red == v) begin i = 0; f = int'(r.green) - int'(r.blue); end
      else if (r.green == v) begin i = 2; f = int'(r.blue) - int'(r.red); end
      else begin i = 4; f = int'(r.red) - int'(r.green); end
      h = (255 * (i * d + f)) / (6 * d);
      if (h < 0) h += 255;
    end
    idx = {h[7:4], s[7:4]};
    e.is_skin = skin_lk[idx] > nonskin_lk[idx];
    e.out_pixel = e.is_skin ? v[7:0] : 8'd0;
    pending.push_back(e);
  endfunction

  function void check_result(res_t a);
    res_t e;
    if (pending.size() == 0) begin
      $error("unexpected result out_pixel=%0d is_skin=%0d", a.out_pixel, a.is_skin);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (a.out_pixel !== e.out_pixel) begin
      $error("out_pixel expected %0d actual %0d", e.out_pixel, a.out_pixel);
      errors++;
    end
    if (a.is_skin !== e.is_skin) begin
      $error("is_skin expected %0d actual %0d", e.is_skin, a.is_skin);
      errors++;
    end
  endfunction
endclass

module hsv_histogram_skin_classifier_unit_test;
  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_stall;
  req_t req = '0;
  logic res_valid;
  logic res_stall = 0;
  res_t res;

  skin_scoreboard sb = new();
  int send_idle_pct = 14;
  int recv_idle_pct = 75;
  longint cycle_count = 0;

  hsv_histogram_skin_classifier_unit dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .req(req), .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: check accepted results and pick the next stall at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) sb.check_result(res);
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Drives one transaction, with random idle cycles in front of it.
  task automatic send(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic load_bin(logic [7:0] idx, logic [15:0] sk, logic [15:0] ns);
    req_t r;
    r = req_t'(65'({$urandom, $urandom, $urandom}));
    r.req_type = REQ_LOAD;
    r.bin_index = idx;
    r.skin_value = sk;
    r.nonskin_value = ns;
    send(r);
  endtask

  task automatic pixel(logic [7:0] rd, logic [7:0] gr, logic [7:0] bl);
    req_t r;
    r = req_t'(65'({$urandom, $urandom, $urandom}));
    r.req_type = REQ_PIXEL;
    r.red = rd;
    r.green = gr;
    r.blue = bl;
    send(r);
  endtask

  task automatic random_item();
    int k;
    k = $urandom_range(99);
    if (k < 15)
      load_bin(8'($urandom), 16'($urandom), 16'($urandom));
    else if (k < 25)
      pixel($urandom_range(1) ? 8'hff : 8'h00, $urandom_range(1) ? 8'hff : 8'h00,
            $urandom_range(1) ? 8'hff : 8'($urandom));
    else
      pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Every bin is loaded first so that no pixel reads an unwritten entry.
    for (n = 0; n < BIN_COUNT; n++) begin
      load_bin(n[7:0], 16'($urandom), 16'($urandom));
    end
    // Directed: table extremes and the equal-entry case.
    load_bin(8'h00, 16'hffff, 16'h0000);
    pixel(0, 0, 0);
    pixel(255, 255, 255);
    load_bin(8'h00, 16'h1234, 16'h1234);
    pixel(77, 77, 77);
    load_bin(8'h00, 16'h0000, 16'hffff);
    pixel(255, 255, 255);
    pixel(255, 0, 0);
    pixel(0, 255, 0);
    pixel(0, 0, 255);
    pixel(255, 0, 1);
    pixel(255, 255, 0);
    pixel(0, 255, 255);
    pixel(255, 0, 255);
    pixel(1, 0, 0);
    pixel(200, 100, 150);
    pixel(100, 200, 50);
    pixel(30, 60, 250);
    pixel(255, 1, 0);
    for (n = 0; n < 1325; n++) begin
      if (n == 260) begin send_idle_pct = 75; recv_idle_pct = 14; end
      if (n == 795) begin send_idle_pct = 0; recv_idle_pct = 0; end
      random_item();
    end
    req_valid <= 1'b0;
    recv_idle_pct = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
